// ----- hdl/hpq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the key ordering function for the binary heap priority queue.
// No dependencies; every other file of the block imports this package.
package hpq_pkg;

    localparam int CAPACITY = 128;
    localparam int KEY_W    = 32;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ENTRY_W  = 8;
    localparam int STATUS_W = 2;

    // Operation codes of an input item.
    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Read address selects.
    localparam logic [2:0] RD_ROOT   = 3'd0;
    localparam logic [2:0] RD_LAST   = 3'd1;
    localparam logic [2:0] RD_PARENT = 3'd2;
    localparam logic [2:0] RD_LEFT   = 3'd3;
    localparam logic [2:0] RD_RIGHT  = 3'd4;

    // Write data selects.
    localparam logic [1:0] WR_KEY    = 2'd0;
    localparam logic [1:0] WR_PARENT = 2'd1;
    localparam logic [1:0] WR_CHILD  = 2'd2;

    typedef struct packed {
        logic                    cmd;
        logic signed [KEY_W-1:0] key_in;
    } t_hpq_in;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        logic [STATUS_W-1:0]     status;
        logic [ENTRY_W-1:0]      entry_count;
    } t_hpq_out;

    // Controller to datapath.
    typedef struct packed {
        logic                load;
        logic                ins_begin;
        logic                cap_root;
        logic                ext_begin;
        logic                take_left;
        logic                take_right;
        logic                rd_en;
        logic [2:0]          rd_src;
        logic                wr_en;
        logic [1:0]          wr_src;
        logic                hole_up;
        logic                hole_down;
        logic                fin_en;
        logic [STATUS_W-1:0] fin_status;
    } t_hpq_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic op_extract;
        logic full;
        logic empty;
        logic at_root;
        logic no_left;
        logic has_right;
        logic key_beats_rd;
        logic child_beats_key;
    } t_hpq_stat;

    // True when key a belongs above key b: smaller wins in min order, larger in max order.
    function automatic logic beats(input logic order_max,
                                   input logic signed [KEY_W-1:0] a,
                                   input logic signed [KEY_W-1:0] b);
        beats = order_max ? (a > b) : (a < b);
    endfunction

endpackage

// ----- hdl/hpq_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the heap priority queue: walks each insert or extract through its sift.
// Depends on hpq_pkg for the command and status structs and the select codes.
module hpq_ctrl import hpq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_hpq_stat i_stat,
    output t_hpq_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_UP_CHK   = 4'd2;
    localparam logic [3:0] S_UP_CMP   = 4'd3;
    localparam logic [3:0] S_EX_ROOT  = 4'd4;
    localparam logic [3:0] S_EX_LAST  = 4'd5;
    localparam logic [3:0] S_DN_CHK   = 4'd6;
    localparam logic [3:0] S_DN_L     = 4'd7;
    localparam logic [3:0] S_DN_R     = 4'd8;
    localparam logic [3:0] S_DN_CMP   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_stat.op_extract) begin
                    if (i_stat.full) begin
                        o_cmd.fin_en     = 1'b1;
                        o_cmd.fin_status = ST_FULL;
                        n_state          = S_IDLE;
                    end else begin
                        o_cmd.ins_begin = 1'b1;
                        n_state         = S_UP_CHK;
                    end
                end else begin
                    if (i_stat.empty) begin
                        o_cmd.fin_en     = 1'b1;
                        o_cmd.fin_status = ST_EMPTY;
                        n_state          = S_IDLE;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_src = RD_ROOT;
                        n_state      = S_EX_ROOT;
                    end
                end
            end
            S_UP_CHK: begin
                if (i_stat.at_root) begin
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wr_src     = WR_KEY;
                    o_cmd.fin_en     = 1'b1;
                    o_cmd.fin_status = ST_OK;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = RD_PARENT;
                    n_state      = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.key_beats_rd) begin
                    o_cmd.wr_src  = WR_PARENT;
                    o_cmd.hole_up = 1'b1;
                    n_state       = S_UP_CHK;
                end else begin
                    o_cmd.wr_src     = WR_KEY;
                    o_cmd.fin_en     = 1'b1;
                    o_cmd.fin_status = ST_OK;
                    n_state          = S_IDLE;
                end
            end
            S_EX_ROOT: begin
                o_cmd.cap_root = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_src   = RD_LAST;
                n_state        = S_EX_LAST;
            end
            S_EX_LAST: begin
                o_cmd.ext_begin = 1'b1;
                n_state         = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (i_stat.no_left) begin
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wr_src     = WR_KEY;
                    o_cmd.fin_en     = 1'b1;
                    o_cmd.fin_status = ST_OK;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = RD_LEFT;
                    n_state      = S_DN_L;
                end
            end
            S_DN_L: begin
                o_cmd.take_left = 1'b1;
                if (i_stat.has_right) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = RD_RIGHT;
                    n_state      = S_DN_R;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_R: begin
                o_cmd.take_right = 1'b1;
                n_state          = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.child_beats_key) begin
                    o_cmd.wr_src    = WR_CHILD;
                    o_cmd.hole_down = 1'b1;
                    n_state         = S_DN_CHK;
                end else begin
                    o_cmd.wr_src     = WR_KEY;
                    o_cmd.fin_en     = 1'b1;
                    o_cmd.fin_status = ST_OK;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // An accepted item always goes to dispatch next.
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_DISPATCH))
        else $error("accepted item did not reach dispatch");

    // Reads and writes never coincide, so a read never sees a same-cycle write.
    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.rd_en && o_cmd.wr_en))
        else $error("read and write issued together");

endmodule

// ----- hdl/hpq_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the heap priority queue: key store, hole and child registers, compare, result.
// Depends on hpq_pkg; driven by hpq_ctrl through t_hpq_cmd and reporting t_hpq_stat.
module hpq_dp import hpq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    input  t_hpq_in   i_item,
    input  t_hpq_cmd  i_cmd,
    output t_hpq_stat o_stat,
    output t_hpq_out  o_res,
    output logic      o_res_stb
);

    logic [KEY_W-1:0]        r_mem [CAPACITY];
    logic signed [KEY_W-1:0] r_rd_data;
    logic                    r_order;
    logic                    r_op;
    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] r_res;
    logic signed [KEY_W-1:0] r_child;
    logic [CNT_W-1:0]        r_child_idx;
    logic [CNT_W-1:0]        r_hole;
    logic [CNT_W-1:0]        r_cnt;
    t_hpq_out                r_out;
    logic                    r_stb;

    logic [CNT_W:0]          w_left;
    logic [CNT_W:0]          w_right;
    logic [CNT_W:0]          w_cnt_x;
    logic [ADDR_W-1:0]       w_rd_addr;
    logic [ADDR_W-1:0]       w_wr_addr;
    logic [KEY_W-1:0]        w_wr_data;

    assign w_left  = {r_hole, 1'b0};
    assign w_right = w_left + 1'b1;
    assign w_cnt_x = {1'b0, r_cnt};

    always_comb begin
        unique case (i_cmd.rd_src)
            RD_ROOT:   w_rd_addr = '0;
            RD_LAST:   w_rd_addr = ADDR_W'(r_cnt - 1'b1);
            RD_PARENT: w_rd_addr = ADDR_W'((r_hole >> 1) - 1'b1);
            RD_LEFT:   w_rd_addr = ADDR_W'(w_left - 1'b1);
            RD_RIGHT:  w_rd_addr = ADDR_W'(w_left);
            default:   w_rd_addr = '0;
        endcase
    end

    assign w_wr_addr = ADDR_W'(r_hole - 1'b1);

    always_comb begin
        unique case (i_cmd.wr_src)
            WR_KEY:    w_wr_data = r_key;
            WR_PARENT: w_wr_data = r_rd_data;
            WR_CHILD:  w_wr_data = r_child;
            default:   w_wr_data = r_key;
        endcase
    end

    // Key store: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Control state: order, fill count, result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 1'b0;
            r_cnt   <= '0;
            r_stb   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_order <= i_cfg_data;
            end
            if (i_cmd.ins_begin) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.ext_begin) begin
                r_cnt <= r_cnt - 1'b1;
            end
            r_stb <= i_cmd.fin_en;
        end
    end

    // Working registers of one operation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_item.cmd;
            r_key <= i_item.key_in;
            r_res <= '0;
        end
        if (i_cmd.ins_begin) begin
            r_hole <= r_cnt + 1'b1;
        end else if (i_cmd.ext_begin) begin
            r_hole <= CNT_W'(1);
        end else if (i_cmd.hole_up) begin
            r_hole <= r_hole >> 1;
        end else if (i_cmd.hole_down) begin
            r_hole <= r_child_idx;
        end
        if (i_cmd.cap_root) begin
            r_res <= r_rd_data;
        end
        if (i_cmd.ext_begin) begin
            r_key <= r_rd_data;
        end
        if (i_cmd.take_left) begin
            r_child     <= r_rd_data;
            r_child_idx <= CNT_W'(w_left);
        end else if (i_cmd.take_right && beats(r_order, r_rd_data, r_child)) begin
            r_child     <= r_rd_data;
            r_child_idx <= CNT_W'(w_right);
        end
        if (i_cmd.fin_en) begin
            r_out.key_out     <= r_res;
            r_out.status      <= i_cmd.fin_status;
            r_out.entry_count <= ENTRY_W'(r_cnt);
        end
    end

    always_comb begin
        o_stat.op_extract      = (r_op == CMD_EXTRACT);
        o_stat.full            = (r_cnt >= CNT_W'(CAPACITY));
        o_stat.empty           = (r_cnt == '0);
        o_stat.at_root         = (r_hole == CNT_W'(1));
        o_stat.no_left         = (w_left > w_cnt_x);
        o_stat.has_right       = (w_right <= w_cnt_x);
        o_stat.key_beats_rd    = beats(r_order, r_key, r_rd_data);
        o_stat.child_beats_key = beats(r_order, r_child, r_key);
    end

    assign o_res     = r_out;
    assign o_res_stb = r_stb;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // Writes land in the live part of the heap (root allowed when it just emptied).
    a_wr_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (r_hole != '0) && ((r_hole <= r_cnt) || (r_hole == CNT_W'(1))))
        else $error("write outside the heap");

    a_stb_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stb |=> !r_stb)
        else $error("result strobe held for two cycles");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stb && (r_out.status == ST_EMPTY)) |-> (r_out.entry_count == '0)
            && (r_out.key_out == '0))
        else $error("empty status with keys held");

endmodule

// ----- hdl/binary_heap_priority_queue.sv -----
`timescale 1ns / 1ps
// Top level of the binary heap priority queue: joins the sequencer and the datapath.
// Depends on hpq_pkg, hpq_ctrl and hpq_dp.
//
// Pulse start with an item while busy is low; the item is taken in that cycle and busy
// rises until the operation is done. Every item yields exactly one result, shown for one
// cycle with o_res_stb high; the receiver cannot stall, so capture it on that strobe.
// An insert opens a hole in the new last slot and lets the key climb: each level reads
// the parent and moves it down while the key beats it, and the key is written where it
// stops. An extract reads the root as the result and the last entry as the moved key,
// then lets it sink, moving the winning child of each level up while it beats the key.
// The key store has one write and one registered read port, used at most once per cycle.
// A refused insert or an empty extract finishes in dispatch. A new item may be started
// in the cycle the previous result is shown. Write order_mode only while busy is low.
module binary_heap_priority_queue import hpq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    // item transfer
    input  logic     start,
    output logic     busy,
    input  t_hpq_in  i_item,
    // result transfer
    output t_hpq_out o_res,
    output logic     o_res_stb,
    // order_mode register: 0 smallest key at the root, 1 largest
    input  logic     i_cfg_we,
    input  logic     i_cfg_data
);

    t_hpq_cmd  w_cmd;
    t_hpq_stat w_stat;

    // Sequence each operation: dispatch, then sift up or down one level at a time.
    hpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Hold keys, track the hole, compare, and register the result.
    hpq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_res      (o_res),
        .o_res_stb  (o_res_stb)
    );

endmodule
